>>> src/qe_table_interpolate_detect_macros.svh
`ifndef QE_TABLE_INTERPOLATE_DETECT_MACROS_SVH
`define QE_TABLE_INTERPOLATE_DETECT_MACROS_SVH

// check that holds in the same cycle as its trigger
`define QETI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check that holds in the cycle after its trigger
`define QETI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/qeti_pkg.sv
package qeti_pkg;

  localparam int WL_W    = 17;
  localparam int QE_W    = 17;
  localparam int RND_W   = 16;
  localparam int IDX_W   = 6;
  localparam int PC_W    = 7;
  localparam int ENTRY_W = WL_W + QE_W;

  localparam logic [QE_W-1:0] QE_ONE = 17'd65536;
  localparam logic [PC_W-1:0] PC_RESET = 7'd2;

  // magnitude divider, two quotient bits per cycle
  localparam int DIV_W     = 36;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DSTEP_W   = $clog2(DIV_STEPS);

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  point_index;
    logic [WL_W-1:0]   wavelength;
    logic [QE_W-1:0]   qe_value;
    logic [RND_W-1:0]  random_value;
  } qeti_item_t;

  typedef struct packed {
    logic [QE_W-1:0] qe_fraction;
    logic            detected;
    logic [1:0]      status;
  } qeti_result_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ORDER = 2'd1,
    STAT_RANGE = 2'd2
  } qeti_status_t;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_IDX_M1,
    RD_MID,
    RD_LO_M1,
    RD_LO
  } qeti_rd_sel_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_RANGE,
    RES_LOAD_OK,
    RES_LOAD_CHK,
    RES_RD_Y,
    RES_Y0,
    RES_INTERP
  } qeti_res_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LD_CHK,
    S_Q_FIRST,
    S_Q_LAST,
    S_S_RD,
    S_S_CMP,
    S_P_LO,
    S_P_HI,
    S_MUL,
    S_DIV_LD,
    S_DIV,
    S_SUM,
    S_DONE
  } qeti_state_t;

  typedef struct packed {
    logic         latch;
    logic         ram_we;
    qeti_rd_sel_t rd_sel;
    logic         cap_lo;
    logic         cap_hi;
    logic         srch_init;
    logic         srch_step;
    logic         mul_go;
    logic         div_start;
    logic         div_step;
    qeti_res_op_t res_op;
    logic         out_load;
  } qeti_cmd_t;

  typedef struct packed {
    logic is_load;
    logic idx_range;
    logic idx_zero;
    logic w_le_rd;
    logic w_ge_rd;
    logic srch_done;
    logic degen;
    logic div_last;
    logic out_free;
  } qeti_flags_t;

endpackage

>>> src/qeti_ram.sv
module qeti_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/qeti_ctrl.sv
module qeti_ctrl
  import qeti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  qeti_flags_t flags,
  output qeti_cmd_t   cmd
);

  qeti_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    item_stall  = 1'b1;
    cmd         = '0;
    cmd.rd_sel  = RD_ZERO;
    cmd.res_op  = RES_NONE;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (flags.is_load) begin
          priority if (flags.idx_range) begin
            cmd.res_op = RES_RANGE;
            state_next = S_DONE;
          end else if (flags.idx_zero) begin
            cmd.ram_we = 1'b1;
            cmd.res_op = RES_LOAD_OK;
            state_next = S_DONE;
          end else begin
            // fetch the previous point for the order check
            cmd.rd_sel = RD_IDX_M1;
            state_next = S_LD_CHK;
          end
        end else begin
          cmd.rd_sel = RD_ZERO;
          state_next = S_Q_FIRST;
        end
      end
      S_LD_CHK: begin
        cmd.ram_we = 1'b1;
        cmd.res_op = RES_LOAD_CHK;
        state_next = S_DONE;
      end
      S_Q_FIRST: begin
        if (flags.w_le_rd) begin
          cmd.res_op = RES_RD_Y;
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_LAST;
          state_next = S_Q_LAST;
        end
      end
      S_Q_LAST: begin
        if (flags.w_ge_rd) begin
          cmd.res_op = RES_RD_Y;
          state_next = S_DONE;
        end else begin
          cmd.srch_init = 1'b1;
          state_next    = S_S_RD;
        end
      end
      S_S_RD: begin
        if (flags.srch_done) begin
          cmd.rd_sel = RD_LO_M1;
          state_next = S_P_LO;
        end else begin
          cmd.rd_sel = RD_MID;
          state_next = S_S_CMP;
        end
      end
      S_S_CMP: begin
        cmd.srch_step = 1'b1;
        state_next    = S_S_RD;
      end
      S_P_LO: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_sel = RD_LO;
        state_next = S_P_HI;
      end
      S_P_HI: begin
        cmd.cap_hi = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (flags.degen) begin
          cmd.res_op = RES_Y0;
          state_next = S_DONE;
        end else begin
          cmd.mul_go = 1'b1;
          state_next = S_DIV_LD;
        end
      end
      S_DIV_LD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (flags.div_last) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.res_op = RES_INTERP;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/qeti_dp.sv
module qeti_dp
  import qeti_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  qeti_item_t      item,
  input  logic            cfg_we,
  input  logic [PC_W-1:0] cfg_data,
  input  qeti_cmd_t       cmd,
  output qeti_flags_t     flags,
  output logic            result_valid,
  input  logic            result_stall,
  output qeti_result_t    result
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = ($clog2(MAX_POINTS + 1) > PC_W) ? $clog2(MAX_POINTS + 1) : PC_W;

  logic [PC_W-1:0]   point_count;
  qeti_item_t        item_q;
  logic [AW-1:0]     lo, hi;
  logic [WL_W-1:0]   x0, x1;
  logic [QE_W-1:0]   y0, y1;
  logic signed [35:0] prod;
  logic [WL_W-1:0]   den;
  logic              neg;
  logic [DIV_W-1:0]  dvd;
  logic [WL_W-1:0]   rem;
  logic [DSTEP_W-1:0] div_cnt;
  logic [QE_W-1:0]   frac;
  qeti_status_t      stat;

  logic [NW-1:0]      pc_ext, n_use;
  logic [AW-1:0]      last, mid, raddr, waddr;
  logic [ENTRY_W-1:0] rdata, wdata;
  logic [WL_W-1:0]    rd_x;
  logic [QE_W-1:0]    rd_y, q_sat;
  logic signed [17:0] dw, dy;
  logic [DIV_W-1:0]   mag;
  logic [WL_W:0]      r1, r2, r1s, r2s;
  logic               ge1, ge2;
  logic signed [37:0] ys, qs, v;
  logic [QE_W-1:0]    v_clamp;

  // points in use, clamped to 2..MAX_POINTS
  always_comb begin
    pc_ext = NW'(point_count);
    if (pc_ext < NW'(2)) begin
      n_use = NW'(2);
    end else if (pc_ext > NW'(MAX_POINTS)) begin
      n_use = NW'(MAX_POINTS);
    end else begin
      n_use = pc_ext;
    end
  end

  assign last  = AW'(n_use - NW'(1));
  assign mid   = lo + ((hi - lo) >> 1);
  assign waddr = AW'(item_q.point_index);
  assign q_sat = (item_q.qe_value > QE_ONE) ? QE_ONE : item_q.qe_value;
  assign wdata = {item_q.wavelength, q_sat};
  assign rd_x  = rdata[ENTRY_W-1 -: WL_W];
  assign rd_y  = rdata[QE_W-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO:   raddr = '0;
      RD_LAST:   raddr = last;
      RD_IDX_M1: raddr = AW'(item_q.point_index - IDX_W'(1));
      RD_MID:    raddr = mid;
      RD_LO_M1:  raddr = lo - AW'(1);
      RD_LO:     raddr = lo;
      default:   raddr = '0;
    endcase
  end

  qeti_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // signed differences for the segment slope
  assign dw = $signed({1'b0, item_q.wavelength}) - $signed({1'b0, x0});
  assign dy = $signed({1'b0, y1}) - $signed({1'b0, y0});
  assign mag = prod[35] ? DIV_W'(~prod + 36'sd1) : DIV_W'(prod);

  // two restoring divide steps per cycle
  always_comb begin
    r1  = {rem, dvd[DIV_W-1]};
    ge1 = r1 >= {1'b0, den};
    r1s = ge1 ? (r1 - {1'b0, den}) : r1;
    r2  = {r1s[WL_W-1:0], dvd[DIV_W-2]};
    ge2 = r2 >= {1'b0, den};
    r2s = ge2 ? (r2 - {1'b0, den}) : r2;
  end

  // quotient gets its sign back and is added to y0, then clamp to 0..one
  always_comb begin
    ys = $signed({21'b0, y0});
    qs = $signed({2'b0, dvd});
    v  = neg ? (ys - qs) : (ys + qs);
    if (v[37]) begin
      v_clamp = '0;
    end else if (v[36:0] > 37'(QE_ONE)) begin
      v_clamp = QE_ONE;
    end else begin
      v_clamp = v[QE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_RESET;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_q <= item;
    end
    if (cmd.srch_init) begin
      lo <= AW'(1);
      hi <= last;
    end else if (cmd.srch_step) begin
      if (rd_x >= item_q.wavelength) begin
        hi <= mid;
      end else begin
        lo <= mid + AW'(1);
      end
    end
    if (cmd.cap_lo) begin
      x0 <= rd_x;
      y0 <= rd_y;
    end
    if (cmd.cap_hi) begin
      x1 <= rd_x;
      y1 <= rd_y;
    end
    if (cmd.mul_go) begin
      prod <= dw * dy;
      den  <= x1 - x0;
    end
    if (cmd.div_start) begin
      neg     <= prod[35];
      dvd     <= mag;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      dvd     <= {dvd[DIV_W-3:0], ge1, ge2};
      rem     <= r2s[WL_W-1:0];
      div_cnt <= div_cnt + DSTEP_W'(1);
    end
    unique case (cmd.res_op)
      RES_NONE: begin
      end
      RES_RANGE: begin
        frac <= '0;
        stat <= STAT_RANGE;
      end
      RES_LOAD_OK: begin
        frac <= '0;
        stat <= STAT_OK;
      end
      RES_LOAD_CHK: begin
        frac <= '0;
        stat <= (rd_x < item_q.wavelength) ? STAT_OK : STAT_ORDER;
      end
      RES_RD_Y: begin
        frac <= rd_y;
        stat <= STAT_OK;
      end
      RES_Y0: begin
        frac <= y0;
        stat <= STAT_OK;
      end
      RES_INTERP: begin
        frac <= v_clamp;
        stat <= STAT_OK;
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      result.qe_fraction <= frac;
      result.detected    <= (item_q.cmd == CMD_QUERY) && ({1'b0, item_q.random_value} < frac);
      result.status      <= stat;
    end
  end

  // output register, refilled as it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    flags.is_load   = item_q.cmd == CMD_LOAD;
    flags.idx_range = NW'(item_q.point_index) >= n_use;
    flags.idx_zero  = item_q.point_index == '0;
    flags.w_le_rd   = item_q.wavelength <= rd_x;
    flags.w_ge_rd   = item_q.wavelength >= rd_x;
    flags.srch_done = lo >= hi;
    flags.degen     = x1 <= x0;
    flags.div_last  = div_cnt == DSTEP_W'(DIV_STEPS - 1);
    flags.out_free  = !result_valid || !result_stall;
  end

endmodule

>>> src/qe_table_interpolate_detect.sv
// A load writes at once (slot 0), is refused (index out of range) or first reads the
// previous point for the order check. A query returns the end value when outside the
// table; inside, k <= ceil(log2(count-1)) search steps, each a read and a compare on
// the single read port, then reads of both segment ends, a multiply and a divide at two
// bits per cycle (both skipped when x1 <= x0). One item in flight; the next
// is taken the cycle after a result is queued. Reset clears control, result_valid, count=2.
module qe_table_interpolate_detect
  import qeti_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  qeti_item_t      item,
  output logic            result_valid,
  input  logic            result_stall,
  output qeti_result_t    result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [PC_W-1:0] cfg_data
);

  qeti_cmd_t   cmd;
  qeti_flags_t flags;

  assign cfg_ready = 1'b1;

  qeti_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .flags      (flags),
    .cmd        (cmd)
  );

  qeti_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .flags        (flags),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> src/qeti_checker.sv
`include "qe_table_interpolate_detect_macros.svh"

module qeti_checker
  import qeti_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         item_valid,
  input logic         item_stall,
  input logic         result_valid,
  input logic         result_stall,
  input qeti_result_t result
);

  `QETI_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result item changed while stalled")

  `QETI_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "second item taken while one is in flight")

  `QETI_ASSERT_NOW(a_result_from_busy, $rose(result_valid), $past(item_stall), "result item appeared without an item in flight")

  `QETI_ASSERT_NOW(a_fraction_range, result_valid, (result.qe_fraction <= QE_ONE) && (!result.detected || result.qe_fraction != '0), "efficiency out of range or detection at zero")

  `QETI_ASSERT_NOW(a_load_result, result_valid && result.status != STAT_OK, result.qe_fraction == '0 && !result.detected, "load item reported a nonzero efficiency")

endmodule

bind qe_table_interpolate_detect qeti_checker u_checker (.*);

>>> tb/tb_top.sv
module tb_top;
  import qeti_pkg::*;

  localparam int TABLE_SLOTS = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 800;

  logic         clk;
  logic         rst;
  logic         item_valid;
  logic         item_stall;
  qeti_item_t   item;
  logic         result_valid;
  logic         result_stall;
  qeti_result_t result;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [PC_W-1:0] cfg_data;

  // predictor copy of the table and the point count
  bit [WL_W-1:0]   tbl_wl [TABLE_SLOTS];
  bit [QE_W-1:0]   tbl_qe [TABLE_SLOTS];
  bit [PC_W-1:0]   tbl_count;

  qeti_result_t expected_qe_results [$];
  qeti_result_t want;
  int           errors;
  int           cycle_count;

  // sender and receiver pacing
  bit  pace_gaps;
  int  burst_left;
  int  stall_pct;
  int  stall_run;
  bit  hold_request;

  qe_table_interpolate_detect i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int active_points();
    if (tbl_count < 2) return 2;
    if (tbl_count > TABLE_SLOTS) return TABLE_SLOTS;
    return int'(tbl_count);
  endfunction

  function automatic logic [QE_W-1:0] interp_efficiency(input logic [WL_W-1:0] w);
    int     n;
    int     lo;
    int     hi;
    int     mid;
    longint x0;
    longint x1;
    longint y0;
    longint y1;
    longint v;
    n = active_points();
    if (w <= tbl_wl[0]) return tbl_qe[0];
    if (w >= tbl_wl[n-1]) return tbl_qe[n-1];
    // first slot in 1..n-1 at or above the key
    lo = 1;
    hi = n - 1;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (tbl_wl[mid] >= w) hi = mid;
      else lo = mid + 1;
    end
    x0 = tbl_wl[lo-1];
    x1 = tbl_wl[lo];
    y0 = tbl_qe[lo-1];
    y1 = tbl_qe[lo];
    if (x1 <= x0) return y0[QE_W-1:0];
    // signed divide truncates toward zero on falling segments
    v = y0 + ((longint'(w) - x0) * (y1 - y0)) / (x1 - x0);
    if (v < 0) v = 0;
    if (v > longint'(QE_ONE)) v = longint'(QE_ONE);
    return v[QE_W-1:0];
  endfunction

  // updates the table copy and returns the result the item should produce
  function automatic qeti_result_t apply_table_item(input qeti_item_t it);
    qeti_result_t r;
    int           n;
    n = active_points();
    r = '0;
    if (it.cmd == CMD_LOAD) begin
      if (it.point_index >= n) begin
        r.status = STAT_RANGE;
      end else begin
        r.status = STAT_OK;
        if (it.point_index != 0 && !(tbl_wl[it.point_index-1] < it.wavelength))
          r.status = STAT_ORDER;
        tbl_wl[it.point_index] = it.wavelength;
        tbl_qe[it.point_index] = (it.qe_value > QE_ONE) ? QE_ONE : it.qe_value;
      end
    end else begin
      r.qe_fraction = interp_efficiency(it.wavelength);
      r.detected    = (it.random_value < r.qe_fraction);
      r.status      = STAT_OK;
    end
    return r;
  endfunction

  function automatic qeti_item_t load_item(input int idx, input logic [WL_W-1:0] w,
                                           input logic [QE_W-1:0] q);
    qeti_item_t it;
    it.cmd          = CMD_LOAD;
    it.point_index  = idx[IDX_W-1:0];
    it.wavelength   = w;
    it.qe_value     = q;
    it.random_value = RND_W'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic qeti_item_t query_item(input logic [WL_W-1:0] w,
                                            input logic [RND_W-1:0] rnd);
    qeti_item_t it;
    it.cmd          = CMD_QUERY;
    it.point_index  = IDX_W'($urandom_range(0, 63));
    it.wavelength   = w;
    it.qe_value     = QE_W'($urandom_range(0, 131071));
    it.random_value = rnd;
    return it;
  endfunction

  function automatic logic [QE_W-1:0] pick_qe();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return QE_ONE;
      2: return QE_W'($urandom_range(65537, 131071));
      default: return QE_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send_item(input qeti_item_t it);
    qeti_result_t predicted;
    if (pace_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    predicted = apply_table_item(it);
    expected_qe_results = {expected_qe_results, predicted};
  endtask

  // sender pauses until every expected result is back
  task automatic drain();
    item_valid <= 1'b0;
    while (expected_qe_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_point_count(input logic [PC_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tbl_count = value;
  endtask

  task automatic fill_table(input int n, input bit sorted);
    int unsigned w;
    int unsigned step_max;
    w = $urandom_range(0, 4000);
    step_max = (131071 - w) / n;
    for (int i = 0; i < n; i++) begin
      send_item(load_item(i, WL_W'(w), pick_qe()));
      w = sorted ? w + $urandom_range(1, step_max) : $urandom_range(0, 131071);
    end
  endtask

  task automatic run_mixed_items(input int count);
    int              n;
    int              idx;
    logic [WL_W-1:0] w;
    n = active_points();
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        // slots below the count are all written by now
        idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        w = ($urandom_range(0, 2) == 0) ? WL_W'($urandom_range(0, 131071)) : tbl_wl[idx];
        send_item(load_item(idx, w, pick_qe()));
      end else begin
        case ($urandom_range(0, 4))
          0, 1: w = WL_W'($urandom_range(0, 131071));
          2, 3: w = WL_W'($urandom_range(tbl_wl[0], tbl_wl[n-1]));
          default: w = WL_W'(tbl_wl[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1);
        endcase
        send_item(query_item(w, RND_W'($urandom_range(0, 65535))));
      end
    end
  endtask

  // reset count of two: ends of the field ranges
  task automatic test_two_point_table();
    send_item(load_item(0, 17'd0, 17'd0));
    send_item(load_item(1, 17'd131071, 17'd65536));
    send_item(load_item(2, 17'd500, 17'd100));
    send_item(load_item(63, 17'd131071, 17'd131071));
    send_item(query_item(17'd0, 16'd0));
    send_item(query_item(17'd131071, 16'd65535));
    send_item(query_item(17'd65536, 16'd32767));
    send_item(query_item(17'd1, 16'd65535));
  endtask

  // order errors, saturation, falling segment, exact points, range refusal
  task automatic test_edge_cases();
    write_point_count(7'd4);
    send_item(load_item(0, 17'd6400, 17'd1000));
    send_item(load_item(1, 17'd12800, 17'd131071));
    send_item(load_item(2, 17'd12800, 17'd0));
    send_item(load_item(2, 17'd9000, 17'd0));
    send_item(load_item(2, 17'd20000, 17'd20000));
    send_item(load_item(3, 17'd131071, 17'd5000));
    send_item(load_item(4, 17'd131071, 17'd7));
    send_item(query_item(17'd0, 16'd0));
    send_item(query_item(17'd6400, 16'd999));
    send_item(query_item(17'd9600, 16'd33268));
    send_item(query_item(17'd12800, 16'd65535));
    send_item(query_item(17'd30000, 16'd0));
    send_item(query_item(17'd131070, 16'd4999));
    send_item(query_item(17'd131071, 16'd5000));
  endtask

  task automatic test_random_tables();
    logic [PC_W-1:0] settings [10] = '{7'd64, 7'd127, 7'd3, 7'd0, 7'd1,
                                       7'd65, 7'd9, 7'd2, 7'd100, 7'd5};
    int phase;
    int sent;
    int n;
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      write_point_count(phase < 10 ? settings[phase] : PC_W'($urandom_range(0, 127)));
      pace_gaps = (phase % 3 != 2);
      stall_pct = (phase % 3 == 2) ? 0 : ((phase % 3 == 0) ? 30 : 65);
      n = active_points();
      fill_table(n, phase % 4 != 2);
      // receiver holds off long enough for the block to back up
      if (phase == 1) hold_request = 1'b1;
      run_mixed_items(60);
      sent += n + 60;
      phase++;
    end
  endtask

  // receiver stall pattern
  initial begin
    result_stall = 1'b0;
    stall_run = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        result_stall <= 1'b0;
        stall_run = 0;
      end else if (stall_run == 0) begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
        stall_run = $urandom_range(1, 8);
      end else begin
        stall_run--;
      end
    end
  end

  task automatic report_mismatch(input string field, input int unsigned want_v,
                                 input int unsigned got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_qe_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %p", $time, result);
      end else begin
        want = expected_qe_results.pop_front();
        if (result.qe_fraction !== want.qe_fraction)
          report_mismatch("qe_fraction", 32'(want.qe_fraction), 32'(result.qe_fraction));
        if (result.detected !== want.detected)
          report_mismatch("detected", 32'(want.detected), 32'(result.detected));
        if (result.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(result.status));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    errors       = 0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    hold_request = 1'b0;
    pace_gaps    = 1'b1;
    burst_left   = 0;
    stall_pct    = 30;
    tbl_count    = PC_RESET;
    foreach (tbl_wl[i]) begin
      tbl_wl[i] = '0;
      tbl_qe[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_two_point_table();
    test_edge_cases();
    test_random_tables();

    drain();
    repeat (64) @(posedge clk);
    if (expected_qe_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_qe_results.size());
    end
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
